[rtl/core/lfla_pkg.sv]
// lfla_pkg: shared types and constants of the life-like automaton step block
// depends on nothing; used by every module of the block by scoped names
`timescale 1ns / 1ps

package lfla_pkg;

    // fixed field widths of the word ports
    localparam int unsigned ROW_IDX_W = 5;
    localparam int unsigned CELLS_W   = 64;
    localparam int unsigned MASK_W    = 9;
    localparam int unsigned CNT_SUM_W = 4;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // configuration register map
    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_BIRTH    = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_SURVIVAL = 3'd4;

    // rule masks after reset: B3/S23
    localparam logic [MASK_W-1:0] BIRTH_RESET    = 9'd8;
    localparam logic [MASK_W-1:0] SURVIVAL_RESET = 9'd12;

    // control of one row cell of the ring
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_STEP = 2'b10
    } t_state;

endpackage

[rtl/core/lfla_row_cell.sv]
// lfla_row_cell: one row of the grid, loaded by a write or fed by its neighbor
// depends on lfla_pkg for the control struct
`timescale 1ns / 1ps

module lfla_row_cell #(
    parameter int unsigned GRID_WIDTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lfla_pkg::t_cell_ctrl      i_ctrl,
    input  logic [GRID_WIDTH-1:0]     i_wdata,
    input  logic [GRID_WIDTH-1:0]     i_next,
    output logic [GRID_WIDTH-1:0]     o_row
);

    logic [GRID_WIDTH-1:0] r_row;
    logic [GRID_WIDTH-1:0] n_row;

    // a write takes priority, a shift takes the neighbor's row
    always_comb begin
        n_row = r_row;
        if (i_ctrl.load) begin
            n_row = i_wdata;
        end else if (i_ctrl.shift) begin
            n_row = i_next;
        end
    end

    // grid starts all dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

endmodule

[rtl/core/lfla_next_row.sv]
// lfla_next_row: new generation of one row from its old row and both neighbors
// depends on lfla_pkg for the mask and count widths
`timescale 1ns / 1ps

module lfla_next_row #(
    parameter int unsigned GRID_WIDTH = 64
) (
    input  logic [GRID_WIDTH-1:0]            i_up,
    input  logic [GRID_WIDTH-1:0]            i_mid,
    input  logic [GRID_WIDTH-1:0]            i_down,
    input  logic [lfla_pkg::MASK_W-1:0]      i_birth,
    input  logic [lfla_pkg::MASK_W-1:0]      i_survival,
    output logic [GRID_WIDTH-1:0]            o_row
);

    localparam int unsigned CW = lfla_pkg::CNT_SUM_W;

    // one neighbor count and rule lookup per column, wrapping at the edges
    for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_col
        localparam int unsigned XL = (x + GRID_WIDTH - 1) % GRID_WIDTH;
        localparam int unsigned XR = (x + 1) % GRID_WIDTH;
        logic [CW-1:0]                 count;
        logic [lfla_pkg::MASK_W-1:0]   rule;

        assign count = CW'(i_up[XL]) + CW'(i_up[x]) + CW'(i_up[XR])
                     + CW'(i_mid[XL]) + CW'(i_mid[XR])
                     + CW'(i_down[XL]) + CW'(i_down[x]) + CW'(i_down[XR]);
        assign rule  = i_mid[x] ? i_survival : i_birth;
        assign o_row[x] = (count < CW'(lfla_pkg::MASK_W)) ? rule[count] : 1'b0;
    end

endmodule

[rtl/core/life_like_automaton_step_top.sv]
// life_like_automaton_step_top: toroidal life-like automaton over a ring of row cells
// depends on lfla_pkg, lfla_row_cell and lfla_next_row
`timescale 1ns / 1ps

// usage
//   command channel: start with i_operation, i_row_index, i_row_cells; a word
//   is taken at a clock edge with start high and busy low.
//   a write word loads one row in the same edge and gives no result; rows at
//   or above GRID_HEIGHT are ignored, bits at or above GRID_WIDTH dropped.
//   a step word rotates the ring of row cells once around, one row through
//   the shared rule unit per cycle; the row just computed enters the tail
//   of the ring while the old one above is kept aside.
//   result channel: o_valid marks each new row for one cycle, rows 0 first,
//   one row per cycle, o_last_row on the final row; the step word's edge sets
//   the step state and each row is registered into the result word. busy is
//   high from a step word's edge until its final row is computed, and the
//   next word is taken while the last row is still on the ports; a write
//   word leaves busy low.
//   the receiver cannot stall; every row is shown exactly once.
//   configuration: APB-style, birth_mask at 0x0, survival_mask at 0x4,
//   pready tied high; to be written by the user only while idle (not enforced).
//   reset (synchronous, active low): all cells dead, masks B3/S23, idle.

module life_like_automaton_step_top #(
    parameter int unsigned GRID_WIDTH  = 64,
    parameter int unsigned GRID_HEIGHT = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_operation,
    input  logic [lfla_pkg::ROW_IDX_W-1:0]      i_row_index,
    input  logic [lfla_pkg::CELLS_W-1:0]        i_row_cells,
    // result channel
    output logic                                o_valid,
    output logic [lfla_pkg::ROW_IDX_W-1:0]      o_out_row_index,
    output logic [lfla_pkg::CELLS_W-1:0]        o_out_row_cells,
    output logic                                o_last_row,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lfla_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int unsigned CNT_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int unsigned IDX_CMP_W = lfla_pkg::ROW_IDX_W + 2;

    lfla_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [GRID_WIDTH-1:0] r_prev, r_first;
    logic [lfla_pkg::MASK_W-1:0] r_birth, r_survival;
    logic r_out_valid;
    logic [lfla_pkg::ROW_IDX_W-1:0] r_out_idx;
    logic [lfla_pkg::CELLS_W-1:0] r_out_cells;
    logic r_out_last;

    logic accept, do_write, do_step, stepping, first_row, last_row;
    logic cfg_wr;
    logic [GRID_WIDTH-1:0] ring [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0] up_row, down_row, new_row;

    assign accept   = start && !busy;
    assign do_write = accept && (i_operation == lfla_pkg::OP_WRITE);
    assign do_step  = accept && (i_operation == lfla_pkg::OP_STEP);
    assign stepping = (r_state == lfla_pkg::S_STEP);
    assign first_row = (r_cnt == '0);
    assign last_row  = (r_cnt == CNT_W'(GRID_HEIGHT - 1));
    assign busy     = stepping;

    // ring of row cells: each takes the row below it, the tail takes the new row
    for (genvar k = 0; k < GRID_HEIGHT; k++) begin : g_ring
        lfla_pkg::t_cell_ctrl ctrl;
        logic [GRID_WIDTH-1:0] feed;

        assign ctrl.load  = do_write &&
                            ({2'b00, i_row_index} == IDX_CMP_W'(k));
        assign ctrl.shift = stepping;
        if (k == GRID_HEIGHT - 1) begin : g_tail
            assign feed = new_row;
        end else begin : g_body
            assign feed = ring[k+1];
        end

        lfla_row_cell #(
            .GRID_WIDTH (GRID_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_wdata (i_row_cells[GRID_WIDTH-1:0]),
            .i_next  (feed),
            .o_row   (ring[k])
        );
    end

    // neighbors of the head row: old row above is kept aside, old row 0 closes the torus
    assign up_row   = first_row ? ring[GRID_HEIGHT-1] : r_prev;
    assign down_row = last_row ? r_first : ring[1];

    lfla_next_row #(
        .GRID_WIDTH (GRID_WIDTH)
    ) u_rule (
        .i_up       (up_row),
        .i_mid      (ring[0]),
        .i_down     (down_row),
        .i_birth    (r_birth),
        .i_survival (r_survival),
        .o_row      (new_row)
    );

    // step sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            lfla_pkg::S_IDLE: begin
                n_cnt = '0;
                if (do_step) begin
                    n_state = lfla_pkg::S_STEP;
                end
            end
            lfla_pkg::S_STEP: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (last_row) begin
                    n_state = lfla_pkg::S_IDLE;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_state = lfla_pkg::S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfla_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= stepping;
        end
    end

    // old rows kept aside during the rotation, and the result word
    always_ff @(posedge i_clk) begin
        if (stepping) begin
            r_prev <= ring[0];
            if (first_row) begin
                r_first <= ring[0];
            end
        end
        r_out_idx   <= lfla_pkg::ROW_IDX_W'(r_cnt);
        r_out_cells <= lfla_pkg::CELLS_W'(new_row);
        r_out_last  <= last_row;
    end

    assign o_valid         = r_out_valid;
    assign o_out_row_index = r_out_idx;
    assign o_out_row_cells = r_out_cells;
    assign o_last_row      = r_out_last;

    // rule mask registers
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth    <= lfla_pkg::BIRTH_RESET;
            r_survival <= lfla_pkg::SURVIVAL_RESET;
        end else if (cfg_wr) begin
            if (paddr == lfla_pkg::ADDR_BIRTH) begin
                r_birth <= pwdata[lfla_pkg::MASK_W-1:0];
            end else if (paddr == lfla_pkg::ADDR_SURVIVAL) begin
                r_survival <= pwdata[lfla_pkg::MASK_W-1:0];
            end
        end
    end

    // register read-back
    always_comb begin
        case (paddr)
            lfla_pkg::ADDR_BIRTH:    prdata = 32'(r_birth);
            lfla_pkg::ADDR_SURVIVAL: prdata = 32'(r_survival);
            default:                 prdata = '0;
        endcase
    end

    assign pready = 1'b1;

endmodule

[verif/lfla_checker.sv]
// lfla_checker: predicts and checks the row words of the life-like automaton step block
// depends on lfla_pkg for widths, operation codes and register addresses
`timescale 1ns / 1ps

module lfla_checker #(
    parameter int unsigned GRID_WIDTH  = 64,
    parameter int unsigned GRID_HEIGHT = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                i_operation,
    input  logic [lfla_pkg::ROW_IDX_W-1:0]      i_row_index,
    input  logic [lfla_pkg::CELLS_W-1:0]        i_row_cells,
    input  logic                                o_valid,
    input  logic [lfla_pkg::ROW_IDX_W-1:0]      o_out_row_index,
    input  logic [lfla_pkg::CELLS_W-1:0]        o_out_row_cells,
    input  logic                                o_last_row,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lfla_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    input  logic                                pready,
    output int                                  fail_count,
    output int                                  rows_pending
);

    localparam logic [lfla_pkg::MASK_W-1:0] BIRTH_AT_RESET   = 9'd8;
    localparam logic [lfla_pkg::MASK_W-1:0] SURVIVE_AT_RESET = 9'd12;
    localparam logic [lfla_pkg::CELLS_W-1:0] LIVE_COLS =
        (GRID_WIDTH >= lfla_pkg::CELLS_W) ? '1 : ((64'd1 << GRID_WIDTH) - 64'd1);

    typedef struct packed {
        logic [lfla_pkg::ROW_IDX_W-1:0] row_idx;
        logic [lfla_pkg::CELLS_W-1:0]   cells;
        logic                           last;
    } t_row_word;

    // shadow copy of the grid and the rule
    logic [lfla_pkg::CELLS_W-1:0] life_grid [GRID_HEIGHT];
    logic [lfla_pkg::MASK_W-1:0]  birth_rule;
    logic [lfla_pkg::MASK_W-1:0]  survive_rule;
    t_row_word                    expected_rows [$];
    t_row_word                    oldest_row;

    // next value of one row from its own and its two wrapped neighbor rows
    function automatic logic [lfla_pkg::CELLS_W-1:0] evolve_row(int unsigned y);
        int unsigned up;
        int unsigned dn;
        int unsigned xl;
        int unsigned xr;
        int unsigned alive_nb;
        logic [lfla_pkg::CELLS_W-1:0] ru;
        logic [lfla_pkg::CELLS_W-1:0] rc;
        logic [lfla_pkg::CELLS_W-1:0] rd;
        logic [lfla_pkg::CELLS_W-1:0] fresh;
        logic [lfla_pkg::MASK_W-1:0]  rule;
        up    = (y + GRID_HEIGHT - 1) % GRID_HEIGHT;
        dn    = (y + 1) % GRID_HEIGHT;
        ru    = life_grid[up];
        rc    = life_grid[y];
        rd    = life_grid[dn];
        fresh = '0;
        for (int unsigned x = 0; x < GRID_WIDTH; x++) begin
            xl = (x + GRID_WIDTH - 1) % GRID_WIDTH;
            xr = (x + 1) % GRID_WIDTH;
            alive_nb = int'(ru[xl]) + int'(ru[x]) + int'(ru[xr])
                     + int'(rc[xl]) + int'(rc[xr])
                     + int'(rd[xl]) + int'(rd[x]) + int'(rd[xr]);
            rule = rc[x] ? survive_rule : birth_rule;
            fresh[x] = rule[alive_nb];
        end
        return fresh;
    endfunction

    // whole generation at once, then queue every new row in order
    task automatic advance_generation();
        logic [lfla_pkg::CELLS_W-1:0] nxt [GRID_HEIGHT];
        t_row_word                    rw;
        for (int unsigned y = 0; y < GRID_HEIGHT; y++)
            nxt[y] = evolve_row(y);
        for (int unsigned y = 0; y < GRID_HEIGHT; y++) begin
            life_grid[y] = nxt[y];
            rw.row_idx   = y[lfla_pkg::ROW_IDX_W-1:0];
            rw.cells     = nxt[y];
            rw.last      = (y == GRID_HEIGHT - 1);
            expected_rows.push_back(rw);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int unsigned y = 0; y < GRID_HEIGHT; y++)
                life_grid[y] = '0;
            birth_rule   = BIRTH_AT_RESET;
            survive_rule = SURVIVE_AT_RESET;
            expected_rows.delete();
        end else begin
            // result words belong to earlier commands, so check them first
            if (o_valid === 1'b1) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch("unexpected row word", o_out_row_cells, '0);
                end else begin
                    oldest_row = expected_rows.pop_front();
                    if (o_out_row_index !== oldest_row.row_idx)
                        report_mismatch("row index", 64'(o_out_row_index),
                                        64'(oldest_row.row_idx));
                    if (o_out_row_cells !== oldest_row.cells)
                        report_mismatch("row cells", o_out_row_cells, oldest_row.cells);
                    if (o_last_row !== oldest_row.last)
                        report_mismatch("last row flag", 64'(o_last_row),
                                        64'(oldest_row.last));
                end
            end
            // rule register writes
            if (psel === 1'b1 && penable === 1'b1 && pwrite === 1'b1 && pready === 1'b1) begin
                case (paddr)
                    lfla_pkg::ADDR_BIRTH:    birth_rule   = pwdata[lfla_pkg::MASK_W-1:0];
                    lfla_pkg::ADDR_SURVIVAL: survive_rule = pwdata[lfla_pkg::MASK_W-1:0];
                    default: ;
                endcase
            end
            // accepted command words
            if (start === 1'b1 && busy === 1'b0) begin
                if (i_operation == lfla_pkg::OP_STEP)
                    advance_generation();
                else if (i_row_index < GRID_HEIGHT)
                    life_grid[i_row_index] = i_row_cells & LIVE_COLS;
            end
        end
        rows_pending = expected_rows.size();
    end

endmodule

[verif/tb_top.sv]
// tb_top: drives command words and rule writes into the life-like automaton step block
// depends on lfla_pkg, life_like_automaton_step_top and lfla_checker
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned GRID_WIDTH    = 64;
    localparam int unsigned GRID_HEIGHT   = 32;
    localparam int unsigned SETTLE_CYCLES = GRID_HEIGHT + 4;
    localparam int unsigned GAP_MAX       = 12;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned PHASE_COUNT   = 11;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               start       = 1'b0;
    logic                               i_operation = lfla_pkg::OP_WRITE;
    logic [lfla_pkg::ROW_IDX_W-1:0]     i_row_index = '0;
    logic [lfla_pkg::CELLS_W-1:0]       i_row_cells = '0;
    logic                               psel        = 1'b0;
    logic                               penable     = 1'b0;
    logic                               pwrite      = 1'b0;
    logic [lfla_pkg::PADDR_W-1:0]       paddr       = '0;
    logic [31:0]                        pwdata      = '0;
    logic                               busy;
    logic                               o_valid;
    logic [lfla_pkg::ROW_IDX_W-1:0]     o_out_row_index;
    logic [lfla_pkg::CELLS_W-1:0]       o_out_row_cells;
    logic                               o_last_row;
    logic [31:0]                        prdata;
    logic                               pready;
    int                                 fail_count;
    int                                 rows_pending;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    life_like_automaton_step_top #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_row_index     (i_row_index),
        .i_row_cells     (i_row_cells),
        .o_valid         (o_valid),
        .o_out_row_index (o_out_row_index),
        .o_out_row_cells (o_out_row_cells),
        .o_last_row      (o_last_row),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    lfla_checker #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_row_index     (i_row_index),
        .i_row_cells     (i_row_cells),
        .o_valid         (o_valid),
        .o_out_row_index (o_out_row_index),
        .o_out_row_cells (o_out_row_cells),
        .o_last_row      (o_last_row),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .rows_pending    (rows_pending)
    );

    // one command word, after an idle gap; returns at the accepting edge
    task automatic send_word(logic op, logic [lfla_pkg::ROW_IDX_W-1:0] idx,
                             logic [lfla_pkg::CELLS_W-1:0] cells, int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_row_index <= idx;
        i_row_cells <= cells;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // stop sending and wait for every pending row word to drain
    task automatic drain_rows();
        start <= 1'b0;
        while (rows_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [lfla_pkg::PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // rule change while idle; junk in the unused upper data bits
    task automatic set_rule(logic [lfla_pkg::MASK_W-1:0] born, logic [lfla_pkg::MASK_W-1:0] keep);
        drain_rows();
        apb_write(lfla_pkg::ADDR_BIRTH, ($urandom & ~32'h1FF) | 32'(born));
        apb_write(lfla_pkg::ADDR_SURVIVAL, ($urandom & ~32'h1FF) | 32'(keep));
    endtask

    task automatic random_words(int unsigned n_words, bit back_to_back, int unsigned step_pct);
        int unsigned gap;
        logic        op;
        logic [lfla_pkg::CELLS_W-1:0] cells;
        for (int unsigned i = 0; i < n_words; i++) begin
            gap = back_to_back ? 0 : $urandom_range(0, GAP_MAX);
            op  = ($urandom_range(0, 99) < step_pct) ? lfla_pkg::OP_STEP : lfla_pkg::OP_WRITE;
            // mix of row densities so patterns both die out and fill up
            case ($urandom_range(0, 5))
                0:       cells = '0;
                1:       cells = '1;
                2:       cells = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                5:       cells = {$urandom, $urandom} | {$urandom, $urandom};
                default: cells = {$urandom, $urandom};
            endcase
            send_word(op, lfla_pkg::ROW_IDX_W'($urandom_range(0, 31)), cells, gap);
        end
    endtask

    // stimulus and verdict
    initial begin
        logic [lfla_pkg::MASK_W-1:0] born;
        logic [lfla_pkg::MASK_W-1:0] keep;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty grid under the reset rule
        send_word(lfla_pkg::OP_STEP, '0, '0, 0);
        // glider straddling the corner where both edges wrap
        send_word(lfla_pkg::OP_WRITE, 5'd30, 64'h8000_0000_0000_0000, $urandom_range(0, GAP_MAX));
        send_word(lfla_pkg::OP_WRITE, 5'd31, 64'h0000_0000_0000_0001, 0);
        send_word(lfla_pkg::OP_WRITE, 5'd0, 64'hC000_0000_0000_0001, 0);
        repeat (4) send_word(lfla_pkg::OP_STEP, '0, '0, $urandom_range(0, GAP_MAX));
        // full row, wrapped corner cells and a lone cell
        send_word(lfla_pkg::OP_WRITE, 5'd0, '1, 0);
        send_word(lfla_pkg::OP_WRITE, 5'd31, 64'h8000_0000_0000_0001, 0);
        send_word(lfla_pkg::OP_WRITE, 5'd1, 64'h1, 0);
        send_word(lfla_pkg::OP_WRITE, 5'd15, '1, $urandom_range(0, GAP_MAX));
        send_word(lfla_pkg::OP_STEP, '0, '0, 0);
        // step whose index and cells must be ignored
        send_word(lfla_pkg::OP_STEP, 5'd31, '1, 0);
        send_word(lfla_pkg::OP_WRITE, 5'd31, '0, 0);
        send_word(lfla_pkg::OP_WRITE, 5'd16, 64'h5555_5555_5555_5555, 0);
        send_word(lfla_pkg::OP_STEP, 5'd16, 64'hAAAA_AAAA_AAAA_AAAA, $urandom_range(0, GAP_MAX));
        random_words(20, 1'b0, 25);

        // rule phases: extremes and the reset rule first, then random rules
        for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       begin born = 9'h000; keep = 9'h000; end
                1:       begin born = 9'h1FF; keep = 9'h1FF; end
                2:       begin born = 9'h001; keep = 9'h100; end
                3:       begin born = 9'h1FF; keep = 9'h000; end
                4:       begin born = 9'h000; keep = 9'h1FF; end
                5:       begin born = 9'h008; keep = 9'h00C; end
                default: begin
                    born = lfla_pkg::MASK_W'($urandom);
                    keep = lfla_pkg::MASK_W'($urandom);
                end
            endcase
            set_rule(born, keep);
            random_words(34, (p % 3) == 1, (p % 2 == 0) ? 20 : 35);
        end

        drain_rows();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // cycles with no accepted word of any kind
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1 ||
                (psel === 1'b1 && penable === 1'b1 && pwrite === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule

[life_like_automaton_step_top.f]
rtl/core/lfla_pkg.sv
rtl/core/lfla_row_cell.sv
rtl/core/lfla_next_row.sv
rtl/core/life_like_automaton_step_top.sv
verif/lfla_checker.sv
verif/tb_top.sv
